// ----- design/swmm_pkg.sv -----
package swmm_pkg;

  // per-cycle control broadcast along the row of cells
  typedef struct packed {
    logic load;   // a transaction is accepted this cycle, every cell shifts
    logic clear;  // start of a new sequence, all held entries die
  } cell_ctrl_t;

endpackage

// ----- design/sliding_window_min_max_sum_top.sv -----
// sliding window min + max over a row of WINDOW_MAX age-ordered cells
// a result is registered in the cells, in each min/max reduction tree level and in the
// output register; while out_stall holds a finished result, the whole pipeline freezes
// throughput: one sample per cycle when not frozen; the tree is fully pipelined
// reset: synchronous, clears all live bits, the fill count and sets window_size to 1
// sample values are not reset; no clearing pass is needed
module sliding_window_min_max_sum_top #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [6:0]                    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          start_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS:0]   min_plus_max
);

  localparam int W  = SAMPLE_BITS;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int WW = (CW > 7) ? CW : 7;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [6:0]           window_size;
  logic [WW-1:0]        win;
  logic [CW-1:0]        samples_seen;
  logic [CW-1:0]        samples_seen_next;
  logic                 advance;
  logic                 accept;
  logic                 emit;
  logic                 tok_cells;
  swmm_pkg::cell_ctrl_t ctrl;

  logic signed [W-1:0]  cell_value [WINDOW_MAX];
  logic                 cell_lo    [WINDOW_MAX];
  logic                 cell_hi    [WINDOW_MAX];
  logic                 keep_lo    [WINDOW_MAX];
  logic                 keep_hi    [WINDOW_MAX];
  logic signed [W-1:0]  lo_leaf    [WINDOW_MAX];
  logic signed [W-1:0]  hi_leaf    [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] lo_live_vec;
  logic [WINDOW_MAX-1:0] hi_live_vec;

  logic                 tree_tok;
  logic signed [W-1:0]  lo_min;
  logic signed [W-1:0]  hi_max;

  // whole pipeline freezes while a finished result waits
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  always_comb begin
    if (window_size == 7'd0) begin
      win = WW'(1);
    end else if (WW'(window_size) > WW'(WINDOW_MAX)) begin
      win = WW'(WINDOW_MAX);
    end else begin
      win = WW'(window_size);
    end
  end

  always_comb begin
    if (start_req) begin
      samples_seen_next = CW'(1);
    end else if (samples_seen == CW'(WINDOW_MAX)) begin
      samples_seen_next = samples_seen;
    end else begin
      samples_seen_next = samples_seen + CW'(1);
    end
  end

  assign emit       = (WW'(samples_seen_next) >= win);
  assign ctrl.load  = accept;
  assign ctrl.clear = start_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= 7'd1;
      samples_seen <= '0;
      tok_cells    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_size <= cfg_wr_data;
      end
      if (accept) begin
        samples_seen <= samples_seen_next;
      end
      if (advance) begin
        tok_cells <= accept && emit;
      end
    end
  end

  genvar k;
  generate
    for (k = 0; k < WINDOW_MAX; k++) begin : g_cell
      if (k == 0) begin : g_head
        swmm_cell #(.W(W), .WW(WW), .CELL_IDX(k)) u_cell (
          .clk      (clk),
          .rst      (rst),
          .ctrl     (ctrl),
          .win      (win),
          .sample   (sample),
          .in_value (sample),
          .in_lo    (1'b1),
          .in_hi    (1'b1),
          .value    (cell_value[k]),
          .live_lo  (cell_lo[k]),
          .live_hi  (cell_hi[k]),
          .keep_lo  (keep_lo[k]),
          .keep_hi  (keep_hi[k])
        );
      end else begin : g_body
        swmm_cell #(.W(W), .WW(WW), .CELL_IDX(k)) u_cell (
          .clk      (clk),
          .rst      (rst),
          .ctrl     (ctrl),
          .win      (win),
          .sample   (sample),
          .in_value (cell_value[k-1]),
          .in_lo    (keep_lo[k-1]),
          .in_hi    (keep_hi[k-1]),
          .value    (cell_value[k]),
          .live_lo  (cell_lo[k]),
          .live_hi  (cell_hi[k]),
          .keep_lo  (keep_lo[k]),
          .keep_hi  (keep_hi[k])
        );
      end
      // dead entries read as neutral values for the reduction
      assign lo_leaf[k]     = cell_lo[k] ? cell_value[k] : MAXV;
      assign hi_leaf[k]     = cell_hi[k] ? cell_value[k] : MINV;
      assign lo_live_vec[k] = cell_lo[k];
      assign hi_live_vec[k] = cell_hi[k];
    end
  endgenerate

  swmm_tree #(.LEAVES(WINDOW_MAX), .W(W)) u_tree (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .in_tok  (tok_cells),
    .lo_leaf (lo_leaf),
    .hi_leaf (hi_leaf),
    .tok     (tree_tok),
    .lo_min  (lo_min),
    .hi_max  (hi_max)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= tree_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      min_plus_max <= {lo_min[W-1], lo_min} + {hi_max[W-1], hi_max};
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  a_newest_live: assert property (@(posedge clk) disable iff (rst)
    accept |=> (cell_lo[0] && cell_hi[0]))
    else $error("newest sample missing from a queue");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && start_req) |=>
      ($countones(lo_live_vec) == 1) && ($countones(hi_live_vec) == 1))
    else $error("start of sequence left old entries live");

  a_unit_window: assert property (@(posedge clk) disable iff (rst)
    (accept && (win == WW'(1))) |=>
      ($countones(lo_live_vec) == 1) && ($countones(hi_live_vec) == 1))
    else $error("window of one holds more than one entry");

endmodule

// ----- design/swmm_cell.sv -----
module swmm_cell #(
  parameter int W        = 32,
  parameter int WW       = 7,
  parameter int CELL_IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  swmm_pkg::cell_ctrl_t ctrl,
  input  logic [WW-1:0]        win,
  input  logic signed [W-1:0]  sample,
  input  logic signed [W-1:0]  in_value,
  input  logic                 in_lo,
  input  logic                 in_hi,
  output logic signed [W-1:0]  value,
  output logic                 live_lo,
  output logic                 live_hi,
  output logic                 keep_lo,
  output logic                 keep_hi
);

  logic expire;

  // this cell holds the sample of age CELL_IDX+1 when the next one arrives
  assign expire  = (WW'(CELL_IDX + 1) >= win);
  assign keep_lo = live_lo && !expire && !(value > sample) && !ctrl.clear;
  assign keep_hi = live_hi && !expire && !(value < sample) && !ctrl.clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      live_lo <= 1'b0;
      live_hi <= 1'b0;
    end else if (ctrl.load) begin
      live_lo <= in_lo;
      live_hi <= in_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value <= in_value;
    end
  end

endmodule

// ----- design/swmm_tree.sv -----
module swmm_tree #(
  parameter int LEAVES = 64,
  parameter int W      = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_tok,
  input  logic signed [W-1:0] lo_leaf [LEAVES],
  input  logic signed [W-1:0] hi_leaf [LEAVES],
  output logic                tok,
  output logic signed [W-1:0] lo_min,
  output logic signed [W-1:0] hi_max
);

  localparam int LV = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int P  = 1 << LV;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] lo_pad  [P];
  logic signed [W-1:0] hi_pad  [P];
  logic signed [W-1:0] lo_node [1:P-1];
  logic signed [W-1:0] hi_node [1:P-1];
  logic [LV-1:0]       tok_q;

  genvar j, n;
  generate
    for (j = 0; j < P; j++) begin : g_pad
      if (j < LEAVES) begin : g_real
        assign lo_pad[j] = lo_leaf[j];
        assign hi_pad[j] = hi_leaf[j];
      end else begin : g_fill
        assign lo_pad[j] = MAXV;
        assign hi_pad[j] = MINV;
      end
    end

    // heap order: node n combines 2n and 2n+1, leaves sit at P..2P-1
    for (n = 1; n < P; n++) begin : g_node
      if (2 * n >= P) begin : g_bottom
        always_ff @(posedge clk) begin
          if (en) begin
            lo_node[n] <= (lo_pad[2*n-P] < lo_pad[2*n+1-P]) ? lo_pad[2*n-P] : lo_pad[2*n+1-P];
            hi_node[n] <= (hi_pad[2*n-P] > hi_pad[2*n+1-P]) ? hi_pad[2*n-P] : hi_pad[2*n+1-P];
          end
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          if (en) begin
            lo_node[n] <= (lo_node[2*n] < lo_node[2*n+1]) ? lo_node[2*n] : lo_node[2*n+1];
            hi_node[n] <= (hi_node[2*n] > hi_node[2*n+1]) ? hi_node[2*n] : hi_node[2*n+1];
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q <= '0;
    end else if (en) begin
      tok_q[0] <= in_tok;
      for (int i = 1; i < LV; i++) begin
        tok_q[i] <= tok_q[i-1];
      end
    end
  end

  assign tok    = tok_q[LV-1];
  assign lo_min = lo_node[1];
  assign hi_max = hi_node[1];

endmodule
